// ===== rtl/wsc_pkg.sv =====
// shared constants, codes and types for the beacon security classifier
package wsc_pkg;

   // element ids and fixed lengths
   localparam logic [7:0] IE_ID_RSN      = 8'd48;
   localparam logic [7:0] IE_ID_VENDOR   = 8'd221;
   localparam logic [7:0] RSN_FIXED_LEN  = 8'd8;
   localparam logic [7:0] WPA_FIXED_LEN  = 8'd12;
   localparam logic [7:0] VENDOR_MIN_LEN = 8'd4;

   // suite type bytes
   localparam logic [7:0] SUITE_TKIP      = 8'd2;
   localparam logic [7:0] SUITE_CCMP      = 8'd4;
   localparam logic [7:0] SUITE_AKM_8021X = 8'd1;

   // vendor oui and type that mark a wpa element
   localparam logic [7:0] WPA_OUI_TYPE [4] = '{8'h00, 8'h50, 8'hF2, 8'h01};

   // element kinds
   localparam logic [1:0] KIND_OTHER = 2'd0;
   localparam logic [1:0] KIND_RSN   = 2'd1;
   localparam logic [1:0] KIND_WPA   = 2'd2;

   // pending flag bit positions
   localparam int FLAG_TKIP  = 0;
   localparam int FLAG_AES   = 1;
   localparam int FLAG_ENT   = 2;
   localparam int FLAG_LENOK = 3;

   // result record bit positions (tkip, aes, ent occupy bits 4:2)
   localparam int REC_FOUND = 0;
   localparam int REC_LENOK = 1;
   localparam int REC_TKIP  = 2;
   localparam int REC_AES   = 3;
   localparam int REC_ENT   = 4;

   // security class codes
   localparam logic [2:0] CLS_OPEN         = 3'd0;
   localparam logic [2:0] CLS_WEP          = 3'd1;
   localparam logic [2:0] CLS_WPA          = 3'd2;
   localparam logic [2:0] CLS_WPA2         = 3'd3;
   localparam logic [2:0] CLS_WPA2_UNKNOWN = 3'd4;

   // per-element decode state
   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] suite_count;
      logic [15:0] akm_count;
      logic [3:0]  flags;
   } wsc_dec_type;

endpackage

// ===== rtl/wsc_value_decode.sv =====
// decode of one value byte of an rsn or wpa element
module wsc_value_decode (
   input  logic                 enable,
   input  logic [7:0]           value_byte,
   input  logic [7:0]           position,
   input  logic [7:0]           element_length,
   input  wsc_pkg::wsc_dec_type dec_cur,
   output wsc_pkg::wsc_dec_type dec_next
);

   logic [7:0]  base;
   logic [15:0] count_full;
   logic [17:0] need_len;
   logic [17:0] list_end_full;
   logic [7:0]  list_end;
   logic [7:0]  list_off;
   logic [7:0]  akm_off;
   logic [7:0]  akm_rel;

   always_comb begin
      base          = (dec_cur.kind == wsc_pkg::KIND_RSN) ?
                      wsc_pkg::RSN_FIXED_LEN : wsc_pkg::WPA_FIXED_LEN;
      count_full    = {value_byte, dec_cur.suite_count[7:0]};
      need_len      = {10'd0, base} + {count_full, 2'b00};
      list_end_full = {10'd0, base} + {dec_cur.suite_count, 2'b00};
      list_end      = list_end_full[7:0];
      list_off      = position - base;
      akm_off       = position - list_end;
      akm_rel       = akm_off - 8'd2;
      dec_next      = dec_cur;

      if (enable && dec_cur.kind != wsc_pkg::KIND_OTHER) begin
         if (dec_cur.kind == wsc_pkg::KIND_WPA && position < 8'd4) begin
            // oui and type check
            if (value_byte != wsc_pkg::WPA_OUI_TYPE[position[1:0]]) begin
               dec_next.kind = wsc_pkg::KIND_OTHER;
            end
         end else if (position == base - 8'd3) begin
            // group cipher
            if (value_byte == wsc_pkg::SUITE_TKIP) begin
               dec_next.flags[wsc_pkg::FLAG_TKIP] = 1'b1;
            end else if (value_byte == wsc_pkg::SUITE_CCMP) begin
               dec_next.flags[wsc_pkg::FLAG_AES] = 1'b1;
            end
         end else if (position == base - 8'd2) begin
            dec_next.suite_count = {8'd0, value_byte};
         end else if (position == base - 8'd1) begin
            // count complete: length must cover the pairwise list
            dec_next.suite_count = count_full;
            if ({10'd0, element_length} >= need_len) begin
               dec_next.flags[wsc_pkg::FLAG_LENOK] = 1'b1;
            end
         end else if (position >= base && dec_cur.flags[wsc_pkg::FLAG_LENOK]) begin
            if (position < list_end) begin
               // pairwise suite type byte
               if (list_off[1:0] == 2'd3) begin
                  if (dec_cur.kind == wsc_pkg::KIND_RSN &&
                      value_byte == wsc_pkg::SUITE_TKIP) begin
                     dec_next.flags[wsc_pkg::FLAG_TKIP] = 1'b1;
                  end else if (value_byte == wsc_pkg::SUITE_CCMP) begin
                     dec_next.flags[wsc_pkg::FLAG_AES] = 1'b1;
                  end
               end
            end else if (akm_off == 8'd0) begin
               dec_next.akm_count = {8'd0, value_byte};
            end else if (akm_off == 8'd1) begin
               dec_next.akm_count = {value_byte, dec_cur.akm_count[7:0]};
            end else begin
               // akm suite type byte inside the listed count
               if (akm_rel[1:0] == 2'd3 &&
                   {10'd0, akm_rel[7:2]} < dec_cur.akm_count &&
                   value_byte == wsc_pkg::SUITE_AKM_8021X) begin
                  dec_next.flags[wsc_pkg::FLAG_ENT] = 1'b1;
               end
            end
         end
      end
   end

endmodule

// ===== rtl/wifi_ie_security_classifier.sv =====
// top level of the beacon information-element security classifier
//
// Takes one information-element beat per clock cycle while req_stall is low,
// and walks the id/length/value elements as they stream past; the per-byte
// work is a single pass of position compares and flag updates between the
// state registers. The beat flagged req_last_byte ends the beacon: in the next
// cycle its result (open, WEP, WPA, WPA2 or WPA2 with unknown ciphers, plus
// TKIP, AES and enterprise flags) sits in the output register, and the walker
// is already back in its reset state for the next beacon. req_stall rises only
// while a finished result is held by rsp_stall, so a beacon can follow the
// previous one with no gap.
module wifi_ie_security_classifier (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_ie_byte,
   input  logic       req_byte_valid,
   input  logic       req_last_byte,
   input  logic       req_privacy_cap,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_security_class,
   output logic       rsp_tkip_flag,
   output logic       rsp_aes_flag,
   output logic       rsp_ent_flag
);

   localparam logic [1:0] PH_ID  = 2'd0;
   localparam logic [1:0] PH_LEN = 2'd1;
   localparam logic [1:0] PH_VAL = 2'd2;

   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  length_ff, length_in;
   logic [7:0]  position_ff, position_in;
   logic [4:0]  rsn_result_ff, rsn_result_in;
   logic [4:0]  wpa_result_ff, wpa_result_in;
   logic        stopped_ff, stopped_in;
   wsc_pkg::wsc_dec_type dec_ff, dec_in, dec_next;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  class_ff, class_in;
   logic        tkip_ff, tkip_in;
   logic        aes_ff, aes_in;
   logic        ent_ff, ent_in;

   logic        accept;
   logic [7:0]  position_next;
   logic [1:0]  commit_kind;
   logic [3:0]  commit_flags;
   logic        commit;
   logic [4:0]  commit_rec;
   logic [2:0]  fl;

   // input is held only by a stalled result
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign position_next = position_ff + 8'd1;

   wsc_value_decode u_decode (
      .enable         (accept && req_byte_valid && phase_ff != PH_ID &&
                       phase_ff != PH_LEN),
      .value_byte     (req_ie_byte),
      .position       (position_ff),
      .element_length (length_ff),
      .dec_cur        (dec_ff),
      .dec_next       (dec_next)
   );

   // element walk and commit
   always_comb begin
      phase_in      = phase_ff;
      length_in     = length_ff;
      position_in   = position_ff;
      rsn_result_in = rsn_result_ff;
      wpa_result_in = wpa_result_ff;
      stopped_in    = stopped_ff;
      dec_in        = dec_ff;
      commit        = 1'b0;
      commit_kind   = wsc_pkg::KIND_OTHER;
      commit_flags  = 4'd0;

      if (accept && req_byte_valid) begin
         case (phase_ff)
            PH_ID: begin
               dec_in.kind = wsc_pkg::KIND_OTHER;
               if (!stopped_ff) begin
                  if (req_ie_byte == wsc_pkg::IE_ID_RSN) begin
                     dec_in.kind = wsc_pkg::KIND_RSN;
                  end else if (req_ie_byte == wsc_pkg::IE_ID_VENDOR &&
                               !wpa_result_ff[wsc_pkg::REC_FOUND]) begin
                     dec_in.kind = wsc_pkg::KIND_WPA;
                  end
               end
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               length_in          = req_ie_byte;
               position_in        = 8'd0;
               dec_in.suite_count = 16'd0;
               dec_in.akm_count   = 16'd0;
               dec_in.flags       = 4'd0;
               commit_kind        = dec_ff.kind;
               if (dec_ff.kind == wsc_pkg::KIND_WPA &&
                   req_ie_byte < wsc_pkg::VENDOR_MIN_LEN) begin
                  commit_kind = wsc_pkg::KIND_OTHER;
               end
               dec_in.kind = commit_kind;
               if (req_ie_byte == 8'd0) begin
                  commit = 1'b1;
               end else begin
                  phase_in = PH_VAL;
               end
            end
            default: begin
               dec_in       = dec_next;
               position_in  = position_next;
               commit_kind  = dec_next.kind;
               commit_flags = dec_next.flags;
               if (position_next >= length_ff) begin
                  commit = 1'b1;
               end
            end
         endcase
      end

      // record the finished element
      commit_rec = {commit_flags[wsc_pkg::FLAG_ENT], commit_flags[wsc_pkg::FLAG_AES],
                    commit_flags[wsc_pkg::FLAG_TKIP], commit_flags[wsc_pkg::FLAG_LENOK],
                    1'b1};
      if (commit) begin
         if (commit_kind == wsc_pkg::KIND_RSN) begin
            rsn_result_in = commit_rec;
            stopped_in    = 1'b1;
         end else if (commit_kind == wsc_pkg::KIND_WPA) begin
            wpa_result_in = commit_rec;
         end
         dec_in.kind = wsc_pkg::KIND_OTHER;
         phase_in    = PH_ID;
      end

      // classify from the results including this beat
      fl       = 3'd0;
      class_in = req_privacy_cap ? wsc_pkg::CLS_WEP : wsc_pkg::CLS_OPEN;
      if (rsn_result_in[wsc_pkg::REC_FOUND]) begin
         if (rsn_result_in[wsc_pkg::REC_LENOK]) begin
            if (!rsn_result_in[wsc_pkg::REC_TKIP] && !rsn_result_in[wsc_pkg::REC_AES]) begin
               class_in = wsc_pkg::CLS_WPA2_UNKNOWN;
            end else begin
               class_in = wsc_pkg::CLS_WPA2;
               fl       = rsn_result_in[4:2];
            end
         end
      end else if (wpa_result_in[wsc_pkg::REC_FOUND] && wpa_result_in[wsc_pkg::REC_LENOK]) begin
         class_in = wsc_pkg::CLS_WPA;
         fl       = wpa_result_in[4:2];
      end
      tkip_in = fl[0];
      aes_in  = fl[1];
      ent_in  = fl[2];

      // end of beacon: back to reset state
      if (accept && req_last_byte) begin
         phase_in      = PH_ID;
         length_in     = 8'd0;
         position_in   = 8'd0;
         rsn_result_in = 5'd0;
         wpa_result_in = 5'd0;
         stopped_in    = 1'b0;
         dec_in        = '0;
      end

      // output register handshake
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept && req_last_byte) begin
         rsp_valid_in = 1'b1;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_ID;
         length_ff     <= 8'd0;
         position_ff   <= 8'd0;
         rsn_result_ff <= 5'd0;
         wpa_result_ff <= 5'd0;
         stopped_ff    <= 1'b0;
         dec_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         length_ff     <= length_in;
         position_ff   <= position_in;
         rsn_result_ff <= rsn_result_in;
         wpa_result_ff <= wpa_result_in;
         stopped_ff    <= stopped_in;
         dec_ff        <= dec_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // result payload, loaded with the last beat
   always_ff @(posedge clock) begin
      if (accept && req_last_byte) begin
         class_ff <= class_in;
         tkip_ff  <= tkip_in;
         aes_ff   <= aes_in;
         ent_ff   <= ent_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_security_class = class_ff;
   assign rsp_tkip_flag      = tkip_ff;
   assign rsp_aes_flag       = aes_ff;
   assign rsp_ent_flag       = ent_ff;

   // a finished beacon leaves the walker in its reset state
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_last_byte |=> phase_ff == PH_ID && rsn_result_ff == 5'd0 &&
      wpa_result_ff == 5'd0 && !stopped_ff)
      else $error("state not cleared after last beat");

   // search stops only after an rsn element was recorded
   a_stop_has_rsn: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |-> rsn_result_ff[wsc_pkg::REC_FOUND])
      else $error("search stopped without rsn result");

   // unknown-cipher class carries no flags
   a_unknown_no_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && class_ff == wsc_pkg::CLS_WPA2_UNKNOWN |->
      !tkip_ff && !aes_ff && !ent_ff)
      else $error("flags set with unknown cipher class");

endmodule

// ===== tb/wsc_verdict_checker.sv =====
// checker that predicts each beacon's security verdict and compares it with the classifier
module wsc_verdict_checker
   import wsc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_ie_byte,
   input  logic       req_byte_valid,
   input  logic       req_last_byte,
   input  logic       req_privacy_cap,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [2:0] rsp_security_class,
   input  logic       rsp_tkip_flag,
   input  logic       rsp_aes_flag,
   input  logic       rsp_ent_flag,
   output int         mismatch_count,
   output int         verdicts_pending,
   output int         verdicts_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [1:0] {WALK_ID, WALK_LEN, WALK_VALUE} walk_phase_type;

   typedef struct packed {
      logic [2:0] sec_class;
      logic       tkip;
      logic       aes;
      logic       ent;
   } verdict_type;

   // predicted walker state
   walk_phase_type walk;
   logic [1:0]  elem_kind;
   int          elem_len;
   int          val_pos;
   int          suite_n;
   int          akm_n;
   logic [3:0]  elem_flags;
   logic [4:0]  rsn_rec;
   logic [4:0]  wpa_rec;
   logic        rsn_settled;

   verdict_type expected_verdicts[$];
   int          mismatches = 0;
   int          checked = 0;
   int          pending = 0;

   assign mismatch_count   = mismatches;
   assign verdicts_pending = pending;
   assign verdicts_checked = checked;

   function automatic void clear_walk();
      walk        = WALK_ID;
      elem_kind   = KIND_OTHER;
      elem_len    = 0;
      val_pos     = 0;
      suite_n     = 0;
      akm_n       = 0;
      elem_flags  = '0;
      rsn_rec     = '0;
      wpa_rec     = '0;
      rsn_settled = 1'b0;
   endfunction

   // a complete element records its flags; an rsn element ends the search
   function automatic void commit_element();
      logic [4:0] rec;
      rec = {elem_flags[FLAG_ENT:FLAG_TKIP], elem_flags[FLAG_LENOK], 1'b1};
      if (elem_kind == KIND_RSN) begin
         rsn_rec     = rec;
         rsn_settled = 1'b1;
      end else if (elem_kind == KIND_WPA) begin
         wpa_rec = rec;
      end
      elem_kind = KIND_OTHER;
      walk      = WALK_ID;
   endfunction

   // one value byte of an rsn or wpa candidate element
   function automatic void decode_value(input logic [7:0] b);
      int base;
      int list_end;
      int q;
      int r;
      base = (elem_kind == KIND_RSN) ? int'(RSN_FIXED_LEN) : int'(WPA_FIXED_LEN);
      // vendor oui and type must match
      if (elem_kind == KIND_WPA && val_pos < 4) begin
         if (b != WPA_OUI_TYPE[val_pos])
            elem_kind = KIND_OTHER;
         return;
      end
      // group or multicast cipher type
      if (val_pos == base - 3) begin
         if (b == SUITE_TKIP)
            elem_flags[FLAG_TKIP] = 1'b1;
         else if (b == SUITE_CCMP)
            elem_flags[FLAG_AES] = 1'b1;
         return;
      end
      // pairwise count, little endian, then the length check
      if (val_pos == base - 2) begin
         suite_n = int'(b);
         return;
      end
      if (val_pos == base - 1) begin
         suite_n = suite_n | (int'(b) << 8);
         if (elem_len >= base + 4 * suite_n)
            elem_flags[FLAG_LENOK] = 1'b1;
         return;
      end
      if (val_pos < base || !elem_flags[FLAG_LENOK])
         return;
      list_end = base + 4 * suite_n;
      if (val_pos < list_end) begin
         // pairwise list: wpa unicast tkip counts for nothing
         if (((val_pos - base) & 3) == 3) begin
            if (elem_kind == KIND_RSN && b == SUITE_TKIP)
               elem_flags[FLAG_TKIP] = 1'b1;
            else if (b == SUITE_CCMP)
               elem_flags[FLAG_AES] = 1'b1;
         end
      end else begin
         // akm count and list; entries past the element end never show up
         q = val_pos - list_end;
         if (q == 0) begin
            akm_n = int'(b);
         end else if (q == 1) begin
            akm_n = akm_n | (int'(b) << 8);
         end else begin
            r = q - 2;
            if ((r & 3) == 3 && (r >> 2) < akm_n && b == SUITE_AKM_8021X)
               elem_flags[FLAG_ENT] = 1'b1;
         end
      end
   endfunction

   // verdict at the end of the buffer
   function automatic verdict_type classify(input logic priv);
      verdict_type v;
      logic [2:0]  fl;
      v  = '0;
      fl = '0;
      if (rsn_rec[REC_FOUND]) begin
         if (rsn_rec[REC_LENOK]) begin
            fl = rsn_rec[REC_ENT:REC_TKIP];
            if (!fl[FLAG_TKIP] && !fl[FLAG_AES]) begin
               v.sec_class = CLS_WPA2_UNKNOWN;
               fl          = '0;
            end else begin
               v.sec_class = CLS_WPA2;
            end
         end else begin
            v.sec_class = priv ? CLS_WEP : CLS_OPEN;
         end
      end else if (wpa_rec[REC_FOUND] && wpa_rec[REC_LENOK]) begin
         v.sec_class = CLS_WPA;
         fl          = wpa_rec[REC_ENT:REC_TKIP];
      end else begin
         v.sec_class = priv ? CLS_WEP : CLS_OPEN;
      end
      v.tkip = fl[FLAG_TKIP];
      v.aes  = fl[FLAG_AES];
      v.ent  = fl[FLAG_ENT];
      return v;
   endfunction

   // advance the walker by one accepted beat
   function automatic void take_beat(input logic [7:0] b, input logic bv, input logic last,
                                     input logic priv);
      if (bv) begin
         case (walk)
            WALK_ID: begin
               elem_kind = KIND_OTHER;
               if (!rsn_settled) begin
                  if (b == IE_ID_RSN)
                     elem_kind = KIND_RSN;
                  else if (b == IE_ID_VENDOR && !wpa_rec[REC_FOUND])
                     elem_kind = KIND_WPA;
               end
               walk = WALK_LEN;
            end
            WALK_LEN: begin
               elem_len   = int'(b);
               val_pos    = 0;
               suite_n    = 0;
               akm_n      = 0;
               elem_flags = '0;
               if (elem_kind == KIND_WPA && b < VENDOR_MIN_LEN)
                  elem_kind = KIND_OTHER;
               if (b == 8'd0)
                  commit_element();
               else
                  walk = WALK_VALUE;
            end
            default: begin
               if (elem_kind != KIND_OTHER)
                  decode_value(b);
               val_pos = (val_pos + 1) & 255;
               if (val_pos >= elem_len)
                  commit_element();
            end
         endcase
      end
      if (last) begin
         expected_verdicts.push_back(classify(priv));
         clear_walk();
      end
   endfunction

   // watch both channels
   always @(posedge clock) begin : watch
      verdict_type got;
      verdict_type want;
      if (reset) begin
         clear_walk();
         expected_verdicts.delete();
      end else begin
         // result beat against the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_security_class, rsp_tkip_flag, rsp_aes_flag, rsp_ent_flag};
            if (expected_verdicts.size() == 0) begin
               $display("%0t: unexpected verdict beat: expected none, got class %0d %b%b%b",
                        $time, got.sec_class, got.tkip, got.aes, got.ent);
               mismatches++;
            end else begin
               want = expected_verdicts.pop_front();
               checked++;
               if (got.sec_class !== want.sec_class) begin
                  $display("%0t: security_class expected %0d got %0d",
                           $time, want.sec_class, got.sec_class);
                  mismatches++;
               end
               if (got.tkip !== want.tkip) begin
                  $display("%0t: tkip flag expected %b got %b", $time, want.tkip, got.tkip);
                  mismatches++;
               end
               if (got.aes !== want.aes) begin
                  $display("%0t: aes flag expected %b got %b", $time, want.aes, got.aes);
                  mismatches++;
               end
               if (got.ent !== want.ent) begin
                  $display("%0t: enterprise flag expected %b got %b",
                           $time, want.ent, got.ent);
                  mismatches++;
               end
            end
         end
         // input beat into the predictor
         if (req_valid && !req_stall)
            take_beat(req_ie_byte, req_byte_valid, req_last_byte, req_privacy_cap);
      end
      pending = expected_verdicts.size();
   end

endmodule

// ===== tb/tb_top.sv =====
// top of the classifier testbench: clock, reset, beacon stimulus and the final verdict
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import wsc_pkg::*;

   localparam int BEAT_TARGET  = 1950;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;

   logic       clock           = 1'b0;
   logic       reset           = 1'b1;
   logic       req_valid       = 1'b0;
   logic [7:0] req_ie_byte     = 8'd0;
   logic       req_byte_valid  = 1'b0;
   logic       req_last_byte   = 1'b0;
   logic       req_privacy_cap = 1'b0;
   logic       rsp_stall       = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   logic [2:0] rsp_security_class;
   logic       rsp_tkip_flag;
   logic       rsp_aes_flag;
   logic       rsp_ent_flag;

   int mismatch_count;
   int verdicts_pending;
   int verdicts_checked;
   int byte_beats   = 0;
   int beats_sent   = 0;
   int beacons_sent = 0;
   int cycle_count  = 0;
   bit calm         = 1'b0;

   logic [7:0] ie_buf[$];
   logic [7:0] payload[$];

   wifi_ie_security_classifier DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_ie_byte       (req_ie_byte),
      .req_byte_valid    (req_byte_valid),
      .req_last_byte     (req_last_byte),
      .req_privacy_cap   (req_privacy_cap),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_security_class(rsp_security_class),
      .rsp_tkip_flag     (rsp_tkip_flag),
      .rsp_aes_flag      (rsp_aes_flag),
      .rsp_ent_flag      (rsp_ent_flag)
   );

   wsc_verdict_checker checker_i (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_ie_byte       (req_ie_byte),
      .req_byte_valid    (req_byte_valid),
      .req_last_byte     (req_last_byte),
      .req_privacy_cap   (req_privacy_cap),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_security_class(rsp_security_class),
      .rsp_tkip_flag     (rsp_tkip_flag),
      .rsp_aes_flag      (rsp_aes_flag),
      .rsp_ent_flag      (rsp_ent_flag),
      .mismatch_count    (mismatch_count),
      .verdicts_pending  (verdicts_pending),
      .verdicts_checked  (verdicts_checked)
   );

   // 4 ns clock
   initial begin
      forever #2 clock = ~clock;
   end

   // result side back-pressure
   always @(posedge clock) begin
      rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 27);
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d verdicts outstanding",
                  cycle_count, verdicts_pending);
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // cipher or akm suite type, known and unknown
   function automatic logic [7:0] pick_suite();
      case ($urandom_range(5))
         0:       return SUITE_AKM_8021X;
         1:       return SUITE_TKIP;
         2:       return SUITE_CCMP;
         3:       return 8'd5;
         4:       return 8'd0;
         default: return 8'($urandom);
      endcase
   endfunction

   // pairwise count offset: mostly honest, sometimes off by a little or a lot
   function automatic int count_skew();
      case ($urandom_range(7))
         0:       return $urandom_range(65535);
         1:       return $urandom_range(2) - 1;
         default: return 0;
      endcase
   endfunction

   // bytes cut from the element end (positive) or junk appended (negative)
   function automatic int pick_trim();
      case ($urandom_range(7))
         0, 1:    return $urandom_range(1, 14);
         2:       return -$urandom_range(1, 4);
         default: return 0;
      endcase
   endfunction

   function automatic void push_suite(input bit wpa_form, input logic [7:0] suite);
      if (wpa_form) begin
         payload.push_back(WPA_OUI_TYPE[0]);
         payload.push_back(WPA_OUI_TYPE[1]);
         payload.push_back(WPA_OUI_TYPE[2]);
      end else begin
         payload.push_back(8'h00);
         payload.push_back(8'h0F);
         payload.push_back(8'hAC);
      end
      payload.push_back(suite);
   endfunction

   function automatic void add_element(input logic [7:0] id);
      ie_buf.push_back(id);
      ie_buf.push_back(8'(payload.size()));
      foreach (payload[i])
         ie_buf.push_back(payload[i]);
      payload.delete();
   endfunction

   function automatic void add_filler(input logic [7:0] id, input int len);
      payload.delete();
      repeat (len)
         payload.push_back(8'($urandom));
      add_element(id);
   endfunction

   // rsn element or wpa vendor element with the given suites
   function automatic void add_secured(input bit wpa_form, input logic [7:0] group,
                                       input logic [7:0] pair, input logic [7:0] akm,
                                       input int pair_n, input int akm_n,
                                       input int skew, input int trim, input bit bad_oui);
      logic [15:0] declared;
      int          spoil;
      payload.delete();
      spoil = bad_oui ? $urandom_range(3) : -1;
      if (wpa_form) begin
         for (int i = 0; i < 4; i++)
            payload.push_back(i == spoil ? WPA_OUI_TYPE[i] ^ 8'($urandom_range(1, 255))
                                         : WPA_OUI_TYPE[i]);
      end
      payload.push_back(8'h01);
      payload.push_back(8'h00);
      push_suite(wpa_form, group);
      declared = 16'(pair_n + skew);
      payload.push_back(declared[7:0]);
      payload.push_back(declared[15:8]);
      for (int i = 0; i < pair_n; i++)
         push_suite(wpa_form, i == 0 ? pair : pick_suite());
      payload.push_back(8'(akm_n));
      payload.push_back(8'(akm_n >> 8));
      for (int i = 0; i < akm_n; i++)
         push_suite(wpa_form, i == 0 ? akm : pick_suite());
      if (trim > 0) begin
         repeat (trim)
            if (payload.size() > 0)
               void'(payload.pop_back());
      end else begin
         repeat (-trim)
            payload.push_back(8'($urandom));
      end
      add_element(wpa_form ? IE_ID_VENDOR : IE_ID_RSN);
   endfunction

   // random beacon: a few elements of every sort, sometimes cut short
   function automatic void build_random_beacon();
      int n_elem;
      int cut;
      ie_buf.delete();
      n_elem = $urandom_range(4);
      repeat (n_elem) begin
         case ($urandom_range(9))
            0, 1, 2: add_secured(1'b0, pick_suite(), pick_suite(), pick_suite(),
                                 $urandom_range(3), $urandom_range(3),
                                 count_skew(), pick_trim(), 1'b0);
            3, 4, 5: add_secured(1'b1, pick_suite(), pick_suite(), pick_suite(),
                                 $urandom_range(3), $urandom_range(3),
                                 count_skew(), pick_trim(), $urandom_range(7) == 0);
            6: begin
               case ($urandom_range(2))
                  0:       add_filler(IE_ID_VENDOR, $urandom_range(5));
                  1:       add_filler(IE_ID_RSN, $urandom_range(5));
                  default: add_filler(8'($urandom), $urandom_range(3));
               endcase
            end
            default: add_filler(8'($urandom), ($urandom_range(31) == 0) ?
                                $urandom_range(200, 255) : $urandom_range(12));
         endcase
      end
      // overrun: last element runs past the buffer end
      if ($urandom_range(7) == 0) begin
         cut = $urandom_range(1, 8);
         repeat (cut)
            if (ie_buf.size() > 0)
               void'(ie_buf.pop_back());
      end
   endfunction

   // one input beat, held until accepted
   task automatic send_beat(input logic [7:0] b, input logic bv, input logic last,
                            input logic priv);
      while (!calm && $urandom_range(99) < 27) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_ie_byte     <= b;
      req_byte_valid  <= bv;
      req_last_byte   <= last;
      req_privacy_cap <= priv;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      beats_sent++;
   endtask

   // whole buffer; the end comes either with the final byte or on an empty beat
   task automatic send_beacon(input logic priv);
      bit   end_with_byte;
      logic fin;
      end_with_byte = ie_buf.size() > 0 && $urandom_range(1);
      foreach (ie_buf[i]) begin
         fin = end_with_byte && i == ie_buf.size() - 1;
         if ($urandom_range(24) == 0)
            send_beat(8'($urandom), 1'b0, 1'b0, 1'($urandom));
         send_beat(ie_buf[i], 1'b1, fin, fin ? priv : 1'($urandom));
         byte_beats++;
      end
      if (!end_with_byte)
         send_beat(8'($urandom), 1'b0, 1'b1, priv);
      beacons_sent++;
   endtask

   // stimulus
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty buffers, privacy clear and set
      ie_buf.delete();
      send_beacon(1'b0);
      ie_buf.delete();
      send_beacon(1'b1);
      // rsn with ccmp and 802.1x
      ie_buf.delete();
      add_secured(1'b0, SUITE_CCMP, SUITE_CCMP, SUITE_AKM_8021X, 1, 1, 0, 0, 1'b0);
      send_beacon(1'b1);
      // rsn with tkip group only
      ie_buf.delete();
      add_secured(1'b0, SUITE_TKIP, 8'd5, SUITE_TKIP, 1, 1, 0, 0, 1'b0);
      send_beacon(1'b0);
      // rsn with no known cipher
      ie_buf.delete();
      add_secured(1'b0, 8'd5, 8'd0, SUITE_AKM_8021X, 1, 1, 0, 0, 1'b0);
      send_beacon(1'b1);
      // rsn failing its length check hides a later wpa element
      ie_buf.delete();
      add_secured(1'b0, SUITE_CCMP, SUITE_CCMP, SUITE_AKM_8021X, 1, 1, 3, 0, 1'b0);
      add_secured(1'b1, SUITE_TKIP, SUITE_CCMP, SUITE_AKM_8021X, 1, 1, 0, 0, 1'b0);
      send_beacon(1'b1);
      // wpa with unicast tkip only after a short vendor and an empty element
      ie_buf.delete();
      add_filler(IE_ID_VENDOR, 3);
      add_filler(8'd0, 0);
      add_secured(1'b1, SUITE_CCMP, SUITE_TKIP, SUITE_AKM_8021X, 1, 1, 0, 0, 1'b0);
      send_beacon(1'b0);
      // akm entry cut by the element end
      ie_buf.delete();
      add_secured(1'b0, SUITE_CCMP, SUITE_CCMP, SUITE_AKM_8021X, 1, 1, 0, 2, 1'b0);
      send_beacon(1'b0);
      // rsn overrunning the buffer
      ie_buf.delete();
      add_secured(1'b0, SUITE_CCMP, SUITE_CCMP, SUITE_AKM_8021X, 1, 1, 0, 0, 1'b0);
      void'(ie_buf.pop_back());
      send_beacon(1'b1);

      // random beacons, with a calm stretch in the middle
      while (beats_sent < BEAT_TARGET) begin
         calm = byte_beats >= 700 && byte_beats < 1000;
         build_random_beacon();
         send_beacon(1'($urandom));
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      // drain
      @(posedge clock);
      while (verdicts_pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d beacons in %0d beats (%0d element bytes); %0d verdicts compared",
               beacons_sent, beats_sent, byte_beats, verdicts_checked);
      $display("%0d field mismatches in %0d cycles", mismatch_count, cycle_count);
      if (mismatch_count == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
